// ----- hw/rtl/vfc_pkg.sv -----
// Shared constants, types and structs of the voxel face cull stream.
`timescale 1ns / 1ps

package vfc_pkg;

    localparam int SIDE       = 16;
    localparam int TYPE_BITS  = 8;
    localparam int PLANE      = SIDE * SIDE;
    localparam int VOLUME     = PLANE * SIDE;
    localparam int CELLS      = 2 * PLANE;          // newest entry comes straight from the input
    localparam int STREAM_LEN = VOLUME + PLANE;
    localparam int POS_W      = $clog2(STREAM_LEN);
    localparam int LOC_W      = (SIDE > 1) ? $clog2(SIDE) : 1;
    localparam int CFG_W      = 12;
    localparam int IDX_W      = 2;
    localparam int COORD_W    = 16;
    localparam int KIND_W     = 8;
    localparam int IN_W       = 8;

    localparam logic [IDX_W-1:0] REG_CHUNK_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_CHUNK_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_CHUNK_Z = 2'd2;

    typedef logic [TYPE_BITS-1:0] type_t;
    typedef logic [LOC_W-1:0]     loc_t;
    typedef logic [COORD_W-1:0]   coord_t;

    // Window view after the current shift: center block and its six neighbors.
    typedef struct packed {
        type_t center;
        type_t x_lo;
        type_t x_hi;
        type_t y_lo;
        type_t y_hi;
        type_t z_lo;
        type_t z_hi;
    } taps_t;

    // Local coordinates of the judged block.
    typedef struct packed {
        logic judging;
        loc_t lx;
        loc_t ly;
        loc_t lz;
    } place_t;

    typedef struct packed {
        logic                visible;
        coord_t              world_x;
        coord_t              world_y;
        coord_t              world_z;
        logic [KIND_W-1:0]   kind;
        logic                chunk_end;
    } result_t;

endpackage

// ----- hw/rtl/vfc_cell.sv -----
// One window cell: a block type register that takes its neighbor's value on shift.
`timescale 1ns / 1ps

module vfc_cell
(
    input  logic           clk,
    input  logic           shift,
    input  vfc_pkg::type_t d,
    output vfc_pkg::type_t q
);

    vfc_pkg::type_t val_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            val_reg <= d;
        end
    end

    assign q = val_reg;

endmodule

// ----- hw/rtl/vfc_window.sv -----
// Delay window: chain of cells with fixed taps at the center and six neighbors.
`timescale 1ns / 1ps

module vfc_window
(
    input  logic            clk,
    input  logic            shift,
    input  vfc_pkg::type_t  din,
    output vfc_pkg::taps_t  taps
);

    vfc_pkg::type_t q [vfc_pkg::CELLS];

    genvar i;
    generate
        for (i = 0; i < vfc_pkg::CELLS; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                vfc_cell u_cell
                (
                    .clk   (clk),
                    .shift (shift),
                    .d     (din),
                    .q     (q[i])
                );
            end
            else
            begin : g_body
                vfc_cell u_cell
                (
                    .clk   (clk),
                    .shift (shift),
                    .d     (q[i-1]),
                    .q     (q[i])
                );
            end
        end
    endgenerate

    // Post-shift entry k is cell k-1 today; entry 0 is the incoming item.
    always_comb
    begin
        taps.center = q[vfc_pkg::PLANE - 1];
        taps.x_lo   = q[vfc_pkg::PLANE];
        taps.x_hi   = q[vfc_pkg::PLANE - 2];
        taps.y_lo   = q[vfc_pkg::PLANE + vfc_pkg::SIDE - 1];
        taps.y_hi   = q[vfc_pkg::PLANE - vfc_pkg::SIDE - 1];
        taps.z_lo   = q[vfc_pkg::CELLS - 1];
        taps.z_hi   = din;
    end

endmodule

// ----- hw/rtl/vfc_judge.sv -----
// Face exposure test and world coordinate forming for the judged block.
`timescale 1ns / 1ps

module vfc_judge
(
    input  vfc_pkg::taps_t   taps,
    input  vfc_pkg::place_t  place,
    input  vfc_pkg::coord_t  base_x,
    input  vfc_pkg::coord_t  base_y,
    input  vfc_pkg::coord_t  base_z,
    output vfc_pkg::result_t res
);

    localparam vfc_pkg::loc_t LOC_MAX = vfc_pkg::LOC_W'(vfc_pkg::SIDE - 1);

    logic exposed;
    logic last;

    always_comb
    begin
        // Border neighbors count as air.
        exposed = (place.lx == '0)      || (taps.x_lo == '0) ||
                  (place.lx == LOC_MAX) || (taps.x_hi == '0) ||
                  (place.ly == '0)      || (taps.y_lo == '0) ||
                  (place.ly == LOC_MAX) || (taps.y_hi == '0) ||
                  (place.lz == '0)      || (taps.z_lo == '0) ||
                  (place.lz == LOC_MAX) || (taps.z_hi == '0);
        last = (place.lx == LOC_MAX) && (place.ly == LOC_MAX) && (place.lz == LOC_MAX);

        res = '0;
        if (place.judging)
        begin
            res.visible   = (taps.center != '0) && exposed;
            res.world_x   = base_x + vfc_pkg::COORD_W'(place.lx);
            res.world_y   = base_y + vfc_pkg::COORD_W'(place.ly);
            res.world_z   = base_z + vfc_pkg::COORD_W'(place.lz);
            res.kind      = vfc_pkg::KIND_W'(taps.center);
            res.chunk_end = last;
        end
    end

endmodule

// ----- hw/rtl/voxel_face_cull_stream.sv -----
// Top level of the voxel face cull stream: position count, window, judge, output skid.
`timescale 1ns / 1ps
// A result is registered as its item is accepted; into the skid if the output stalls.
// One item per cycle unless in_stall; the window shifts once per accepted item.
// Each chunk is SIDE^3 block items followed by SIDE^2 drain items; the first SIDE^2
// results of a chunk are all zero, the rest judge the block SIDE^2 items back.
// Reset (rst_n low, asynchronous) clears position, chunk registers and valids;
// window cells are not reset since stale entries are always masked at the chunk border.

module voxel_face_cull_stream
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_we,
    input  logic [vfc_pkg::IDX_W-1:0]     cfg_index,
    input  logic [vfc_pkg::CFG_W-1:0]     cfg_data,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [vfc_pkg::IN_W-1:0]      block_type,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          visible,
    output logic signed [vfc_pkg::COORD_W-1:0] world_x,
    output logic signed [vfc_pkg::COORD_W-1:0] world_y,
    output logic signed [vfc_pkg::COORD_W-1:0] world_z,
    output logic [vfc_pkg::KIND_W-1:0]    kind,
    output logic                          chunk_end
);

    localparam vfc_pkg::loc_t LOC_MAX = vfc_pkg::LOC_W'(vfc_pkg::SIDE - 1);
    localparam logic [vfc_pkg::POS_W-1:0] POS_PLANE  = vfc_pkg::POS_W'(vfc_pkg::PLANE);
    localparam logic [vfc_pkg::POS_W-1:0] POS_VOLUME = vfc_pkg::POS_W'(vfc_pkg::VOLUME);
    localparam logic [vfc_pkg::POS_W-1:0] POS_LAST   = vfc_pkg::POS_W'(vfc_pkg::STREAM_LEN - 1);

    // ------------------------------------------------------------------
    // Chunk base registers: chunk coordinate times SIDE, kept pre-scaled.
    // ------------------------------------------------------------------
    vfc_pkg::coord_t base_x_reg, base_y_reg, base_z_reg;
    vfc_pkg::coord_t cfg_ext;
    vfc_pkg::coord_t cfg_scaled;

    assign cfg_ext    = {{(vfc_pkg::COORD_W - vfc_pkg::CFG_W){cfg_data[vfc_pkg::CFG_W-1]}},
                         cfg_data};
    assign cfg_scaled = vfc_pkg::COORD_W'(cfg_ext * vfc_pkg::COORD_W'(vfc_pkg::SIDE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_x_reg <= '0;
            base_y_reg <= '0;
            base_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vfc_pkg::REG_CHUNK_X: base_x_reg <= cfg_scaled;
                vfc_pkg::REG_CHUNK_Y: base_y_reg <= cfg_scaled;
                vfc_pkg::REG_CHUNK_Z: base_z_reg <= cfg_scaled;
                default:              ;  // index beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Position within the chunk stream and local coordinates of the
    // block being judged.
    // ------------------------------------------------------------------
    logic                          in_acc;
    logic [vfc_pkg::POS_W-1:0]     pos_reg, pos_next;
    vfc_pkg::loc_t                 lx_reg, ly_reg, lz_reg;
    vfc_pkg::loc_t                 lx_next, ly_next, lz_next;
    logic                          judging;
    vfc_pkg::type_t                incoming;

    assign in_acc   = in_valid && !in_stall;
    assign judging  = (pos_reg >= POS_PLANE);
    // Drain items shift air into the window.
    assign incoming = (pos_reg < POS_VOLUME) ? vfc_pkg::type_t'(block_type) : '0;

    always_comb
    begin
        pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
        lx_next  = lx_reg;
        ly_next  = ly_reg;
        lz_next  = lz_reg;
        if (judging)
        begin
            lx_next = (lx_reg == LOC_MAX) ? '0 : lx_reg + 1'b1;
            if (lx_reg == LOC_MAX)
            begin
                ly_next = (ly_reg == LOC_MAX) ? '0 : ly_reg + 1'b1;
                if (ly_reg == LOC_MAX)
                begin
                    lz_next = (lz_reg == LOC_MAX) ? '0 : lz_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            lx_reg  <= '0;
            ly_reg  <= '0;
            lz_reg  <= '0;
        end
        else if (in_acc)
        begin
            pos_reg <= pos_next;
            lx_reg  <= lx_next;
            ly_reg  <= ly_next;
            lz_reg  <= lz_next;
        end
    end

    // ------------------------------------------------------------------
    // Window chain and judge. The judge sees the window as it stands
    // after this item's shift, so the result is ready at the accept edge.
    // ------------------------------------------------------------------
    vfc_pkg::taps_t   taps;
    vfc_pkg::place_t  place;
    vfc_pkg::result_t res;

    vfc_window u_window
    (
        .clk   (clk),
        .shift (in_acc),
        .din   (incoming),
        .taps  (taps)
    );

    always_comb
    begin
        place.judging = judging;
        place.lx      = lx_reg;
        place.ly      = ly_reg;
        place.lz      = lz_reg;
    end

    vfc_judge u_judge
    (
        .taps   (taps),
        .place  (place),
        .base_x (base_x_reg),
        .base_y (base_y_reg),
        .base_z (base_z_reg),
        .res    (res)
    );

    // ------------------------------------------------------------------
    // Output register plus skid entry. in_stall is registered: it rises
    // only once the skid holds an item, so a stalled output still lets
    // one more item in.
    // ------------------------------------------------------------------
    logic             out_valid_reg;
    logic             skid_valid_reg;
    vfc_pkg::result_t out_data_reg;
    vfc_pkg::result_t skid_data_reg;
    logic             out_take;

    assign out_take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_acc)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (in_acc)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_data_reg <= res;
            end
            else
            begin
                skid_data_reg <= res;
            end
        end
    end

    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign visible   = out_data_reg.visible;
    assign world_x   = out_data_reg.world_x;
    assign world_y   = out_data_reg.world_y;
    assign world_z   = out_data_reg.world_z;
    assign kind      = out_data_reg.kind;
    assign chunk_end = out_data_reg.chunk_end;

endmodule

// ----- hw/rtl/vfc_checker.sv -----
// Port-level checks of the voxel face cull stream, bound to the top level.
`timescale 1ns / 1ps

module vfc_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_stall,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          visible,
    input  logic [vfc_pkg::COORD_W-1:0]   world_x,
    input  logic [vfc_pkg::KIND_W-1:0]    kind,
    input  logic                          chunk_end
);

    // Input is held back only while a result is waiting at the output.
    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");

    // Visible implies a non-air block.
    a_visible_solid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && visible |-> kind != '0)
        else $error("air block reported visible");

    // The last block of a chunk sits on three borders, so any solid one is visible.
    a_corner_visible: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && chunk_end && kind != '0 |-> visible)
        else $error("solid corner block not visible");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(world_x))
        else $error("stalled result changed");

endmodule

bind voxel_face_cull_stream vfc_checker u_vfc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .visible   (visible),
    .world_x   (world_x),
    .kind      (kind),
    .chunk_end (chunk_end)
);

// ----- verif/tb.sv -----
// Self-checking testbench for the voxel face cull stream.
`timescale 1ns / 1ps

module tb;

    import vfc_pkg::*;

    // The predictor keeps the whole delay window: newest item plus CELLS older ones.
    localparam int RING_LEN    = CELLS + 1;
    localparam int CYCLE_LIMIT = 1_000_000;
    // Receiver hold-off: starts inside the gap-free phase, where the sender never pauses.
    localparam int HOLD_AT     = 450;
    localparam int HOLD_CYCLES = 400;

    // Index 3 is past the register list; the block must ignore writes to it.
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum int {FLOW, LIGHT, HEAVY, TOGGLE, HOLD} stall_style_t;

    // ------------------------------------------------------------------
    // Culling predictor and store of pending results
    // ------------------------------------------------------------------
    class cull_board;
        type_t   ring [RING_LEN];
        int      head;
        int      stream_pos;
        int      origin [3];
        result_t due [$];
        int      mismatches;
        int      strays;
        int      n_visible;
        int      n_hidden;
        int      n_air;
        int      n_fill;
        int      n_ends;

        function new();
            foreach (ring[i])
                ring[i] = '0;
            head       = 0;
            stream_pos = 0;
            origin     = '{0, 0, 0};
            mismatches = 0;
            strays     = 0;
            n_visible  = 0;
            n_hidden   = 0;
            n_air      = 0;
            n_fill     = 0;
            n_ends     = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_CHUNK_X: origin[0] = int'($signed(data));
                REG_CHUNK_Y: origin[1] = int'($signed(data));
                REG_CHUNK_Z: origin[2] = int'($signed(data));
                default: ;
            endcase
        endfunction

        // Entry 'back' items behind the newest one.
        function type_t tap(int back);
            return ring[(head + RING_LEN - back) % RING_LEN];
        endfunction

        function void take_block(logic [IN_W-1:0] value);
            int      c;
            int      lx;
            int      ly;
            int      lz;
            type_t   center;
            logic    exposed;
            result_t r;

            // drain items push air whatever the input carries
            head       = (head + 1) % RING_LEN;
            ring[head] = (stream_pos < VOLUME) ? type_t'(value) : '0;
            r          = '0;

            if (stream_pos >= PLANE)
            begin
                c      = stream_pos - PLANE;
                lx     = c % SIDE;
                ly     = (c / SIDE) % SIDE;
                lz     = c / PLANE;
                center = tap(PLANE);
                // outside the chunk counts as air
                exposed = (lx == 0)        || (tap(PLANE + 1) == 0)
                       || (lx == SIDE - 1) || (tap(PLANE - 1) == 0)
                       || (ly == 0)        || (tap(PLANE + SIDE) == 0)
                       || (ly == SIDE - 1) || (tap(PLANE - SIDE) == 0)
                       || (lz == 0)        || (tap(2 * PLANE) == 0)
                       || (lz == SIDE - 1) || (tap(0) == 0);
                r.visible   = (center != 0) && exposed;
                r.world_x   = coord_t'(origin[0] * SIDE + lx);
                r.world_y   = coord_t'(origin[1] * SIDE + ly);
                r.world_z   = coord_t'(origin[2] * SIDE + lz);
                r.kind      = KIND_W'(center);
                r.chunk_end = (c == VOLUME - 1);
                if (r.visible)
                    n_visible++;
                else if (center != 0)
                    n_hidden++;
                else
                    n_air++;
                if (r.chunk_end)
                    n_ends++;
            end
            else
            begin
                n_fill++;
            end

            due = {due, r};
            stream_pos = (stream_pos + 1 == STREAM_LEN) ? 0 : stream_pos + 1;
        endfunction

        function void note_diff(string field, longint want, longint seen);
            if (want != seen)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, seen);
            end
        endfunction

        function void match_result(result_t got);
            result_t want;

            if (due.size() == 0)
            begin
                strays++;
                $display("%0t: result with nothing expected, got %h", $time, got);
                return;
            end
            want = due.pop_front();
            note_diff("visible", want.visible, got.visible);
            note_diff("world_x", $signed(want.world_x), $signed(got.world_x));
            note_diff("world_y", $signed(want.world_y), $signed(got.world_y));
            note_diff("world_z", $signed(want.world_z), $signed(got.world_z));
            note_diff("kind", want.kind, got.kind);
            note_diff("chunk_end", want.chunk_end, got.chunk_end);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                cfg_we     = 1'b0;
    logic [IDX_W-1:0]    cfg_index  = '0;
    logic [CFG_W-1:0]    cfg_data   = '0;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    logic [IN_W-1:0]     block_type = '0;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    logic                visible;
    logic signed [COORD_W-1:0] world_x;
    logic signed [COORD_W-1:0] world_y;
    logic signed [COORD_W-1:0] world_z;
    logic [KIND_W-1:0]   kind;
    logic                chunk_end;

    cull_board board = new();

    int items_accepted = 0;
    int reg_writes     = 0;
    int phases_run     = 0;
    int cycles         = 0;
    int failures;

    // Opening of the stream: field extremes and single-bit patterns, with air
    // mixed in so that the first row of the chunk gets judged against both kinds.
    logic [IN_W-1:0] opening_types [20] = '{
        8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA, 8'h00, 8'h00,
        8'h0F, 8'hF0, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h00, 8'hFF
    };

    voxel_face_cull_stream uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .block_type (block_type),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .visible    (visible),
        .world_x    (world_x),
        .world_y    (world_y),
        .world_z    (world_z),
        .kind       (kind),
        .chunk_end  (chunk_end)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: run exceeded %0d cycles, %0d results still pending",
                 $time, CYCLE_LIMIT, board.due.size());
        $display("tb failed");
        $finish;
    end

    // Result monitor: outputs are sampled at the rising edge, before the DUT updates.
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.visible   = visible;
            got.world_x   = world_x;
            got.world_y   = world_y;
            got.world_z   = world_z;
            got.kind      = kind;
            got.chunk_end = chunk_end;
            board.match_result(got);
        end
    end

    // Receiver: stall pattern in segments of random style and length. Once, inside the
    // gap-free phase, it holds off long enough to back up the input.
    initial
    begin
        int           seg_len;
        stall_style_t style;
        bit           held_off;
        logic         s;

        held_off = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            seg_len = $urandom_range(16, 160);
            style   = stall_style_t'($urandom_range(0, 3));
            if (!held_off && items_accepted >= HOLD_AT)
            begin
                held_off = 1'b1;
                seg_len  = HOLD_CYCLES;
                style    = HOLD;
            end
            repeat (seg_len)
            begin
                case (style)
                    FLOW:    s = 1'b0;
                    LIGHT:   s = ($urandom_range(0, 3) == 0);
                    HEAVY:   s = ($urandom_range(0, 9) < 6);
                    TOGGLE:  s = ~out_stall;
                    default: s = 1'b1;
                endcase
                out_stall <= s;
                @(negedge clk);
            end
        end
    end

    // Register write; called at a falling edge with the block idle. The write enable
    // is lowered before it returns, so it drops between back-to-back writes.
    task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.set_reg(idx, data);
        reg_writes++;
        @(negedge clk);
    endtask

    // Wait, at falling edges, until every expected result has come back.
    task automatic settle();
        while (board.due.size() != 0)
            @(negedge clk);
    endtask

    // Present one item and hold it until accepted; returns at the next falling edge.
    task automatic offer(input logic [IN_W-1:0] value);
        in_valid   <= 1'b1;
        block_type <= value;
        do
            @(posedge clk);
        while (in_stall);
        board.take_block(value);
        items_accepted++;
        @(negedge clk);
    endtask

    function automatic logic [IN_W-1:0] pick_type(int air_pct);
        if ($urandom_range(0, 99) < air_pct)
            return '0;
        return IN_W'($urandom_range(1, 255));
    endfunction

    // Send count items of the chunk stream, going on from where the last call ended.
    // Past the SIDE^3 block items the drain items carry junk. air_pct sets the block
    // density; bursty adds sender gaps.
    task automatic run_items(input int count, input int air_pct, input bit bursty);
        int              burst_left;
        int              i;
        logic [IN_W-1:0] value;

        burst_left = $urandom_range(1, 48);
        for (i = 0; i < count; i++)
        begin
            if (bursty && burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8))
                    @(negedge clk);
                burst_left = $urandom_range(1, 48);
            end

            if (board.stream_pos >= VOLUME)
                value = IN_W'($urandom);
            else if (items_accepted < $size(opening_types))
                value = opening_types[items_accepted];
            else
                value = pick_type(air_pct);
            offer(value);
            if (burst_left > 0)
                burst_left--;
        end
        in_valid <= 1'b0;
        phases_run++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // phase 0: fill and first rows; most negative x, most positive y, plus a
        // write past the list
        put_reg(REG_CHUNK_X, 12'h800);
        put_reg(REG_CHUNK_Y, 12'h7FF);
        put_reg(REG_CHUNK_Z, 12'h000);
        put_reg(REG_UNUSED, 12'hFFF);
        run_items(400, 50, 1'b1);

        // phase 1: solid blocks, no sender gaps; the long receiver hold-off lands here.
        // Origin registers are read as each result forms, so a mid-chunk change must
        // show up on the very next judged block.
        settle();
        put_reg(REG_CHUNK_X, 12'h7FF);
        put_reg(REG_CHUNK_Y, 12'h800);
        put_reg(REG_CHUNK_Z, 12'hFFF);
        run_items(500, 0, 1'b0);

        // phase 2: dense with scattered air, random origin
        settle();
        put_reg(REG_CHUNK_X, CFG_W'($urandom));
        put_reg(REG_CHUNK_Y, CFG_W'($urandom));
        put_reg(REG_CHUNK_Z, CFG_W'($urandom));
        put_reg(REG_UNUSED, CFG_W'($urandom));
        run_items(350, 10, 1'b1);

        settle();
        repeat (4) @(negedge clk);

        failures = board.mismatches + board.strays + board.due.size();
        if (board.due.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, board.due.size());
        $display("Covered %0d items in %0d stream phases with %0d register writes.",
                 items_accepted, phases_run, reg_writes);
        $display("Judged %0d visible, %0d hidden, %0d air, %0d fill, %0d chunk ends.",
                 board.n_visible, board.n_hidden, board.n_air, board.n_fill, board.n_ends);
        if (failures == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
